>>> rtl/cmax_pkg.sv
// Shared types and constants for the column maximum and arg-maximum block.
package cmax_pkg;

    // Default store depth (columns per frame)
    localparam int MAX_COLUMNS_DEF = 2048;

    // Fixed field widths
    localparam int DATA_W    = 8;
    localparam int ROW_W     = 16;
    localparam int COL_CNT_W = 12;
    localparam int COL_IDX_W = 11;

    // Classifier-to-datapath queue depth (power of two)
    localparam int FIFO_DEPTH = 4;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // One classified element on its way to the datapath
    typedef struct packed {
        logic [DATA_W-1:0]    value;
        logic [COL_CNT_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 first_row;
        logic                 last_row;
        logic                 last_col;
    } entry_t;

endpackage

>>> rtl/cmax_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmax_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/cmax_fifo.sv
// Short register queue between the element classifier and the datapath.
module cmax_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cmax_pkg::entry_t  push_data,
    input  logic              pop,
    output cmax_pkg::entry_t  head,
    output logic              full,
    output logic              empty
);

    localparam int PW = (cmax_pkg::FIFO_DEPTH > 1) ? $clog2(cmax_pkg::FIFO_DEPTH) : 1;
    localparam int CW = $clog2(cmax_pkg::FIFO_DEPTH + 1);

    cmax_pkg::entry_t slot_reg [cmax_pkg::FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(cmax_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(cmax_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(cmax_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/cmax_front.sv
// Front end: accepts elements, tracks row and column, classifies each beat.
module cmax_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [cmax_pkg::DATA_W-1:0]         s_element,
    input  logic [cmax_pkg::ROW_W-1:0]          eff_rows,
    input  logic [cmax_pkg::COL_CNT_W-1:0]      eff_cols,
    input  logic                                restart,
    input  logic                                fifo_full,
    output logic                                push,
    output cmax_pkg::entry_t                    push_data
);

    logic [cmax_pkg::COL_CNT_W-1:0] col_reg, col_next;
    logic [cmax_pkg::ROW_W-1:0]     row_reg, row_next;
    logic                           last_row, last_col;

    assign s_ready = !fifo_full;
    assign push    = s_valid && s_ready;

    // Classification of the current position
    assign last_row = (row_reg == eff_rows - 1'b1);
    assign last_col = (col_reg == eff_cols - 1'b1);

    always_comb begin
        push_data.value     = s_element;
        push_data.col       = col_reg;
        push_data.row       = row_reg;
        push_data.first_row = (row_reg == '0);
        push_data.last_row  = last_row;
        push_data.last_col  = last_col;
    end

    // Raster position, restarted by any register write
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (push) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> rtl/cmax_back.sv
// Back end: read-modify-write of the column store and the result register.
module cmax_back #(
    parameter int MAX_COLUMNS = cmax_pkg::MAX_COLUMNS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                fifo_empty,
    input  cmax_pkg::entry_t                    head,
    output logic                                pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cmax_pkg::COL_IDX_W-1:0]      m_column_index,
    output logic [cmax_pkg::DATA_W-1:0]         m_max_value,
    output logic [cmax_pkg::ROW_W-1:0]          m_max_row,
    output logic                                m_last_column
);

    localparam int AW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int WORD_W = cmax_pkg::DATA_W + cmax_pkg::ROW_W;

    cmax_pkg::entry_t b_entry_reg;
    logic             b_valid_reg;
    logic             fwd_reg;
    logic [cmax_pkg::DATA_W-1:0] wr_max_reg;
    logic [cmax_pkg::ROW_W-1:0]  wr_row_reg;

    logic [WORD_W-1:0]           rd_word;
    logic [cmax_pkg::DATA_W-1:0] old_max, new_max;
    logic [cmax_pkg::ROW_W-1:0]  old_row, new_row;
    logic                        b_done, b_adv, wr_en, emit;

    logic                        m_valid_reg;
    logic [cmax_pkg::COL_IDX_W-1:0] m_col_reg;
    logic [cmax_pkg::DATA_W-1:0] m_max_reg;
    logic [cmax_pkg::ROW_W-1:0]  m_row_reg;
    logic                        m_last_reg;

    // Column store: maximum in the low byte, its row above
    cmax_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_COLUMNS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(b_entry_reg.col)),
        .wr_data ({new_row, new_max}),
        .rd_en   (pop),
        .rd_addr (AW'(head.col)),
        .rd_data (rd_word)
    );

    // Stage handshake: the result slot frees on the beat it is taken
    assign emit   = b_valid_reg && b_entry_reg.last_row;
    assign b_done = !emit || !m_valid_reg || m_ready;
    assign b_adv  = !b_valid_reg || b_done;
    assign pop    = !fifo_empty && b_adv;
    assign wr_en  = b_valid_reg && b_done;

    // Compare and update, forwarding the write of the previous beat
    always_comb begin
        old_max = fwd_reg ? wr_max_reg : rd_word[cmax_pkg::DATA_W-1:0];
        old_row = fwd_reg ? wr_row_reg : rd_word[WORD_W-1:cmax_pkg::DATA_W];
        if (b_entry_reg.first_row) begin
            new_max = b_entry_reg.value;
            new_row = '0;
        end else if (b_entry_reg.value > old_max) begin
            new_max = b_entry_reg.value;
            new_row = b_entry_reg.row;
        end else begin
            new_max = old_max;
            new_row = old_row;
        end
    end

    // Datapath stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end else if (b_adv) begin
            b_valid_reg <= pop;
            fwd_reg     <= b_valid_reg && (head.col == b_entry_reg.col);
        end
    end

    // Stage payload and last written word
    always_ff @(posedge aclk) begin
        if (b_adv) begin
            b_entry_reg <= head;
        end
        if (wr_en) begin
            wr_max_reg <= new_max;
            wr_row_reg <= new_row;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit && b_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit && b_done) begin
            m_col_reg  <= cmax_pkg::COL_IDX_W'(b_entry_reg.col);
            m_max_reg  <= new_max;
            m_row_reg  <= new_row;
            m_last_reg <= b_entry_reg.last_col;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_column_index = m_col_reg;
    assign m_max_value    = m_max_reg;
    assign m_max_row      = m_row_reg;
    assign m_last_column  = m_last_reg;

endmodule

>>> rtl/column_max_and_argmax_u8.sv
// Top level of the column maximum and arg-maximum block.
//
//  channel   dir  handshake             payload
//  s_        in   s_valid / s_ready     s_element[7:0]
//  m_        out  m_valid / m_ready     m_column_index, m_max_value, m_max_row, m_last_column
//  apb       in   psel/penable/pwrite   paddr[2:0], pwdata, prdata (pready tied high)
//
//  One element a cycle while the queue has room; results pass the stage and result registers.
//  The rate is set by the column store's single read and single write port,
//  with the previous beat's write forwarded when it hits the same column.
//  Reset is synchronous, active low; it clears the queue, stages and position.
//  A register write restarts the frame at row 0, column 0.
//  A stalled result holds its register while the queue absorbs up to four elements.
module column_max_and_argmax_u8 #(
    parameter int MAX_COLUMNS = cmax_pkg::MAX_COLUMNS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [cmax_pkg::DATA_W-1:0]         s_element,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cmax_pkg::COL_IDX_W-1:0]      m_column_index,
    output logic [cmax_pkg::DATA_W-1:0]         m_max_value,
    output logic [cmax_pkg::ROW_W-1:0]          m_max_row,
    output logic                                m_last_column,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cmax_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cmax_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cmax_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [cmax_pkg::ROW_W-1:0]     row_count_reg;
    logic [cmax_pkg::COL_CNT_W-1:0] column_count_reg;
    logic [cmax_pkg::ROW_W-1:0]     eff_rows;
    logic [cmax_pkg::COL_CNT_W-1:0] eff_cols;
    logic                           cfg_wr;

    logic             fifo_push, fifo_pop, fifo_full, fifo_empty;
    cmax_pkg::entry_t push_data, head;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= cmax_pkg::ROW_W'(1);
            column_count_reg <= cmax_pkg::COL_CNT_W'(1);
        end else if (cfg_wr) begin
            case (paddr[2])
                cmax_pkg::REG_ROW_COUNT:
                    row_count_reg <= pwdata[cmax_pkg::ROW_W-1:0];
                cmax_pkg::REG_COLUMN_COUNT:
                    column_count_reg <= pwdata[cmax_pkg::COL_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            cmax_pkg::REG_ROW_COUNT:
                prdata = cmax_pkg::APB_DATA_W'(row_count_reg);
            cmax_pkg::REG_COLUMN_COUNT:
                prdata = cmax_pkg::APB_DATA_W'(column_count_reg);
            default:
                prdata = '0;
        endcase
    end

    // Effective frame size: zero means one, columns saturate at the store depth
    always_comb begin
        eff_rows = (row_count_reg == '0) ? cmax_pkg::ROW_W'(1) : row_count_reg;
        if (column_count_reg == '0) begin
            eff_cols = cmax_pkg::COL_CNT_W'(1);
        end else if (32'(column_count_reg) > 32'(MAX_COLUMNS)) begin
            eff_cols = cmax_pkg::COL_CNT_W'(MAX_COLUMNS);
        end else begin
            eff_cols = column_count_reg;
        end
    end

    cmax_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_element (s_element),
        .eff_rows  (eff_rows),
        .eff_cols  (eff_cols),
        .restart   (cfg_wr),
        .fifo_full (fifo_full),
        .push      (fifo_push),
        .push_data (push_data)
    );

    cmax_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data (push_data),
        .pop       (fifo_pop),
        .head      (head),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    cmax_back #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fifo_empty     (fifo_empty),
        .head           (head),
        .pop            (fifo_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_column_index (m_column_index),
        .m_max_value    (m_max_value),
        .m_max_row      (m_max_row),
        .m_last_column  (m_last_column)
    );

`ifndef SYNTHESIS
    // Queue never written while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_push && fifo_full))
        else $error("element pushed into a full queue");

    // Datapath never pops an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_pop && fifo_empty))
        else $error("datapath popped an empty queue");

    // Reset leaves no result pending
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the column maximum and arg-maximum block.
module tb;

    localparam int STORE_DEPTH     = cmax_pkg::MAX_COLUMNS_DEF;
    localparam int RANDOM_ELEMENTS = 300;
    localparam int TALL_ROWS       = 100;
    localparam int DRAIN_CYCLES    = 12;
    localparam int REPORT_LIMIT    = 10;

    // One final column result as the block should emit it
    typedef struct packed {
        logic [cmax_pkg::COL_IDX_W-1:0] col;
        logic [cmax_pkg::DATA_W-1:0]    maxv;
        logic [cmax_pkg::ROW_W-1:0]     row;
        logic                           last;
    } col_result_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic [cmax_pkg::DATA_W-1:0]     s_element = '0;
    logic                            m_ready   = 1'b0;
    logic                            psel      = 1'b0;
    logic                            penable   = 1'b0;
    logic                            pwrite    = 1'b0;
    logic [cmax_pkg::APB_ADDR_W-1:0] paddr     = '0;
    logic [cmax_pkg::APB_DATA_W-1:0] pwdata    = '0;
    logic                            s_ready;
    logic                            m_valid;
    logic [cmax_pkg::COL_IDX_W-1:0]  m_column_index;
    logic [cmax_pkg::DATA_W-1:0]     m_max_value;
    logic [cmax_pkg::ROW_W-1:0]      m_max_row;
    logic                            m_last_column;
    logic [cmax_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    always #5 aclk = ~aclk;

    column_max_and_argmax_u8 uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_element      (s_element),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_column_index (m_column_index),
        .m_max_value    (m_max_value),
        .m_max_row      (m_max_row),
        .m_last_column  (m_last_column),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Shadow registers, frame position and column stores
    logic [cmax_pkg::ROW_W-1:0]     row_count_shadow    = 16'd1;
    logic [cmax_pkg::COL_CNT_W-1:0] column_count_shadow = 12'd1;
    int                             next_col = 0;
    int                             next_row = 0;
    logic [cmax_pkg::DATA_W-1:0]    col_max    [STORE_DEPTH];
    logic [cmax_pkg::ROW_W-1:0]     col_argmax [STORE_DEPTH];
    col_result_t                    pending_results[$];

    int errors        = 0;
    int elements_in   = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int input_stalls  = 0;
    bit src_jitter    = 1'b1;
    bit sink_jitter   = 1'b1;
    int hold_request  = 0;
    int hold_left     = 0;
    col_result_t got_exp;

    // Advance the column maximum state by one element
    function automatic void track_element(logic [cmax_pkg::DATA_W-1:0] v);
        int rows;
        int cols;
        int c;
        int r;
        col_result_t res;
        rows = (row_count_shadow == 0) ? 1 : int'(row_count_shadow);
        cols = (column_count_shadow == 0) ? 1 : int'(column_count_shadow);
        if (cols > STORE_DEPTH) cols = STORE_DEPTH;
        c = (next_col >= cols) ? 0 : next_col;
        r = (next_row >= rows) ? 0 : next_row;
        if (r == 0) begin
            col_max[c]    = v;
            col_argmax[c] = '0;
        end else if (v > col_max[c]) begin
            col_max[c]    = v;
            col_argmax[c] = cmax_pkg::ROW_W'(r);
        end
        if (r == rows - 1) begin
            res.col  = cmax_pkg::COL_IDX_W'(c);
            res.maxv = col_max[c];
            res.row  = col_argmax[c];
            res.last = (c == cols - 1);
            pending_results.push_back(res);
        end
        c++;
        if (c >= cols) begin
            c = 0;
            r++;
            if (r >= rows) r = 0;
        end
        next_col = c;
        next_row = r;
    endfunction

    function automatic void flag_mismatch(string what, longint exp_v, longint act_v);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t",
                     what, exp_v, act_v, $time);
    endfunction

    // Element value with a bias towards ties and extremes
    function automatic logic [cmax_pkg::DATA_W-1:0] draw_value(int base);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return cmax_pkg::DATA_W'($urandom_range(0, 255));
        if (r < 9) return cmax_pkg::DATA_W'(base + $urandom_range(0, 3));
        return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endfunction

    // Result checker: every accepted beat against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("UNEXPECTED result beat for column %0d at %0t",
                             m_column_index, $time);
            end else begin
                got_exp = pending_results.pop_front();
                if (m_column_index !== got_exp.col)
                    flag_mismatch("column_index", got_exp.col, m_column_index);
                if (m_max_value !== got_exp.maxv)
                    flag_mismatch("max_value", got_exp.maxv, m_max_value);
                if (m_max_row !== got_exp.row)
                    flag_mismatch("max_row", got_exp.row, m_max_row);
                if (m_last_column !== got_exp.last)
                    flag_mismatch("last_column", got_exp.last, m_last_column);
            end
        end
        if (aresetn && s_valid && !s_ready) input_stalls++;
    end

    // Result sink: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_request > 0) begin
            hold_left    = hold_request - 1;
            hold_request = 0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(sink_jitter && $urandom_range(0, 99) < 14);
        end
    end

    // Offer one element beat; entered and left at a falling edge
    task automatic send_element(input logic [cmax_pkg::DATA_W-1:0] v);
        while (src_jitter && $urandom_range(0, 99) < 14) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_element <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        track_element(v);
        elements_in++;
        @(negedge aclk);
    endtask

    // Stop offering and let every outstanding result drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [cmax_pkg::APB_DATA_W-1:0] data);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == cmax_pkg::REG_ROW_COUNT) row_count_shadow = data[cmax_pkg::ROW_W-1:0];
        else column_count_shadow = data[cmax_pkg::COL_CNT_W-1:0];
        next_col = 0;
        next_row = 0;
        reg_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input logic idx);
        logic [cmax_pkg::APB_DATA_W-1:0] got;
        logic [cmax_pkg::APB_DATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        want = (idx == cmax_pkg::REG_ROW_COUNT) ? cmax_pkg::APB_DATA_W'(row_count_shadow)
                                                : cmax_pkg::APB_DATA_W'(column_count_shadow);
        if (got !== want) flag_mismatch("register readback", want, got);
    endtask

    // After reset: one row, one column, every beat is a result
    task automatic test_reset_defaults();
        check_reg(cmax_pkg::REG_ROW_COUNT);
        check_reg(cmax_pkg::REG_COLUMN_COUNT);
        send_element(8'h00);
        send_element(8'hFF);
        send_element(8'h5A);
    endtask

    // One-row frame emits its row as it arrives
    task automatic test_single_row();
        write_reg(cmax_pkg::REG_ROW_COUNT, 32'd1);
        write_reg(cmax_pkg::REG_COLUMN_COUNT, 32'd4);
        send_element(8'h80);
        send_element(8'h01);
        send_element(8'hFF);
        send_element(8'h00);
    endtask

    // Ties keep the earliest row; a larger value in the last row wins
    task automatic test_ties();
        write_reg(cmax_pkg::REG_ROW_COUNT, 32'd4);
        write_reg(cmax_pkg::REG_COLUMN_COUNT, 32'd3);
        send_element(8'd10); send_element(8'd200); send_element(8'd0);
        send_element(8'd10); send_element(8'd255); send_element(8'd1);
        send_element(8'd9);  send_element(8'd255); send_element(8'd1);
        send_element(8'd11); send_element(8'd254); send_element(8'd0);
    endtask

    // Zero counts act as one; upper data bits are ignored
    task automatic test_zero_counts();
        write_reg(cmax_pkg::REG_ROW_COUNT, 32'hABCD_0000);
        write_reg(cmax_pkg::REG_COLUMN_COUNT, 32'h1234_5000);
        check_reg(cmax_pkg::REG_ROW_COUNT);
        check_reg(cmax_pkg::REG_COLUMN_COUNT);
        send_element(8'h33);
        send_element(8'hCC);
        send_element(8'h00);
    endtask

    // Column count saturates at the store depth; one full-width row
    task automatic test_wide_frames();
        int i;
        write_reg(cmax_pkg::REG_ROW_COUNT, 32'd1);
        write_reg(cmax_pkg::REG_COLUMN_COUNT, 32'hFFFF_FFFF);
        check_reg(cmax_pkg::REG_COLUMN_COUNT);
        for (i = 0; i < STORE_DEPTH; i++) send_element(draw_value(100));
    endtask

    // A register write part-way through a frame starts a new one
    task automatic test_restart();
        int i;
        write_reg(cmax_pkg::REG_ROW_COUNT, 32'd3);
        write_reg(cmax_pkg::REG_COLUMN_COUNT, 32'd5);
        for (i = 0; i < 7; i++) send_element(draw_value(40));
        write_reg(cmax_pkg::REG_ROW_COUNT, 32'd3);
        for (i = 0; i < 15; i++) send_element(draw_value(40));
        for (i = 0; i < 12; i++) send_element(draw_value(40));
        write_reg(cmax_pkg::REG_COLUMN_COUNT, 32'd2);
        for (i = 0; i < 6; i++) send_element(draw_value(40));
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        int i;
        write_reg(cmax_pkg::REG_ROW_COUNT, 32'd1);
        write_reg(cmax_pkg::REG_COLUMN_COUNT, 32'd16);
        src_jitter   = 1'b0;
        hold_request = 300;
        for (i = 0; i < 64; i++) send_element(draw_value(200));
        src_jitter = 1'b1;
    endtask

    // Tall narrow frame: the maximum turns up only in the final row
    task automatic test_tall_frame();
        int i;
        write_reg(cmax_pkg::REG_ROW_COUNT, 32'(TALL_ROWS));
        write_reg(cmax_pkg::REG_COLUMN_COUNT, 32'd1);
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        for (i = 0; i < TALL_ROWS - 1; i++)
            send_element(cmax_pkg::DATA_W'($urandom_range(0, 254)));
        send_element(8'hFF);
        wait_idle();
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;
    endtask

    // Random frame shapes, whole frames plus the odd abandoned one
    task automatic test_random();
        int start;
        int phase;
        int rows;
        int cols;
        int eff_rows;
        int eff_cols;
        int flen;
        int frames;
        int base;
        int i;
        int sel;
        start = elements_in;
        phase = 0;
        while (elements_in - start < RANDOM_ELEMENTS) begin
            // a stretch of phases with no idling at either end
            src_jitter  = !(phase >= 2 && phase < 5);
            sink_jitter = src_jitter;
            sel  = $urandom_range(0, 9);
            rows = (sel == 0) ? 0 : (sel < 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
            sel  = $urandom_range(0, 9);
            cols = (sel == 0) ? 0 : (sel < 7) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            sel  = $urandom_range(0, 3);
            if (sel != 1)
                write_reg(cmax_pkg::REG_ROW_COUNT, {16'($urandom), 16'(rows)});
            if (sel != 2)
                write_reg(cmax_pkg::REG_COLUMN_COUNT, {20'($urandom), 12'(cols)});
            if (sel == 3)
                write_reg(cmax_pkg::REG_ROW_COUNT, {16'($urandom), 16'(rows)});
            if ($urandom_range(0, 9) < 3) begin
                check_reg(cmax_pkg::REG_ROW_COUNT);
                check_reg(cmax_pkg::REG_COLUMN_COUNT);
            end
            eff_rows = (row_count_shadow == 0) ? 1 : int'(row_count_shadow);
            eff_cols = (column_count_shadow == 0) ? 1 : int'(column_count_shadow);
            if (eff_cols > STORE_DEPTH) eff_cols = STORE_DEPTH;
            flen   = eff_rows * eff_cols;
            frames = (flen > 200) ? 1 : 1 + $urandom_range(0, 2);
            base   = $urandom_range(0, 252);
            for (i = 0; i < frames * flen; i++) send_element(draw_value(base));
            if (flen > 1 && $urandom_range(0, 9) < 3)
                for (i = $urandom_range(1, flen - 1); i > 0; i--) send_element(draw_value(base));
            phase++;
        end
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_single_row();
        test_ties();
        test_zero_counts();
        test_restart();
        test_backpressure();
        test_wide_frames();
        test_tall_frame();
        test_random();
        wait_idle();
        $display("Covered %0d elements over %0d register writes: zero counts, ties,",
                 elements_in, reg_writes);
        $display("restarts, a saturated full-width row and a tall frame; %0d result beats,",
                 results_seen);
        $display("input held off for %0d cycles.", input_stalls);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(20_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/cmax_pkg.sv
rtl/cmax_ram.sv
rtl/cmax_fifo.sv
rtl/cmax_front.sv
rtl/cmax_back.sv
rtl/column_max_and_argmax_u8.sv
tb/tb.sv
